/* hdl/fce_pkg.sv */
// fce_pkg: shared types and constants of the fenwick count engine
// no dependencies; imported by fenwick_count_engine, fce_step_unit and fce_port_checker

package fce_pkg;

    // field widths fixed by the item format
    localparam int POS_W   = 11;
    localparam int WALK_W  = 12;
    localparam int COUNT_W = 16;
    localparam int STAT_W  = 2;

    // register reset value
    localparam logic [POS_W-1:0] N_USED_RST = 11'd1024;

    // saturation limit of the reported count
    localparam logic [47:0] COUNT_MAX = 48'd65535;

    // operation codes
    localparam logic OP_INC   = 1'b0;
    localparam logic OP_COUNT = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ORDER = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_UP,
        ST_WALK_HI,
        ST_WALK_LO,
        ST_FINISH
    } t_state;

    // walk control from the shared step unit
    typedef struct packed {
        logic              pos_ok;
        logic [WALK_W-1:0] next_pos;
    } t_step_ctl;

endpackage

/* hdl/fenwick_count_engine.sv */
// fenwick_count_engine: binary indexed tree of occurrence counts
// depends on fce_pkg, fce_cell_ram, fce_step_unit
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  item in  | start, busy          | i_op, i_low_pos, i_high_pos
//  result   | o_valid (1 cycle)    | o_range_count, o_status
//  config   | i_cfg_we             | i_cfg_wdata (n_used)
//
// one cell read per cycle through the single read port of the cell ram
// count word: busy through a walk down the set bits of high_pos, then one down those of low_pos-1
// increment word: busy through the chain steps upward from high_pos
// rejected word: goes straight to the finish state; busy drops in the cycle the result strobe is high
// after reset a clearing pass zeroes every cell, busy stays high
// results cannot be stalled; each one stands on the ports for one cycle

module fenwick_count_engine
    import fce_pkg::*;
#(
    parameter int MAX_POSITIONS = 1024,
    parameter int CELL_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [POS_W-1:0]   i_low_pos,
    input  logic [POS_W-1:0]   i_high_pos,
    input  logic               i_cfg_we,
    input  logic [POS_W-1:0]   i_cfg_wdata,
    output logic               o_valid,
    output logic [COUNT_W-1:0] o_range_count,
    output logic [STAT_W-1:0]  o_status
);

    localparam int AW       = $clog2(MAX_POSITIONS);
    localparam int ACC_W    = CELL_BITS + 4;
    localparam int SIZE_CAP = (MAX_POSITIONS > 2047) ? 2047 : MAX_POSITIONS;

    // control registers
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_pend, n_pend;
    logic              r_valid, n_valid;
    logic [POS_W-1:0]  r_n_used;

    // payload registers
    logic [WALK_W-1:0]  r_pos, n_pos;
    logic [AW-1:0]      r_wr_addr, n_wr_addr;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [ACC_W-1:0]   r_sum_hi, n_sum_hi;
    logic [POS_W-1:0]   r_lo_m1, n_lo_m1;
    logic               r_op, n_op;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [COUNT_W-1:0] r_count_out, n_count_out;
    logic [STAT_W-1:0]  r_status_out, n_status_out;

    logic [POS_W-1:0]     size;
    logic                 hi_bad, lo_bad;
    logic [STAT_W-1:0]    chk_status;
    logic                 walking;
    logic [31:0]          rd_addr_wide;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [CELL_BITS-1:0] mem_wdata;
    logic [CELL_BITS-1:0] mem_rdata;
    t_step_ctl            step_ctl;
    logic [CELL_BITS-1:0] inc_cell;
    logic [ACC_W-1:0]     acc_next;
    logic [ACC_W-1:0]     diff;
    logic [47:0]          diff_wide;

    // effective tree size
    assign size = (r_n_used > POS_W'(SIZE_CAP)) ? POS_W'(SIZE_CAP) : r_n_used;

    // range checks on the incoming word
    always_comb begin
        hi_bad = (i_high_pos == '0) || (i_high_pos > size);
        lo_bad = (i_low_pos == '0) || (i_low_pos > size);
        if (i_op == OP_INC) begin
            chk_status = hi_bad ? STATUS_RANGE : STATUS_OK;
        end else if (lo_bad || hi_bad) begin
            chk_status = STATUS_RANGE;
        end else if (i_low_pos > i_high_pos) begin
            chk_status = STATUS_ORDER;
        end else begin
            chk_status = STATUS_OK;
        end
    end

    assign walking      = (r_state == ST_WALK_UP) || (r_state == ST_WALK_HI) ||
                          (r_state == ST_WALK_LO);
    assign rd_addr_wide = 32'(r_pos) - 32'd1;
    assign rd_addr      = rd_addr_wide[AW-1:0];

    // shared step unit
    fce_step_unit #(
        .CELL_BITS (CELL_BITS),
        .ACC_W     (ACC_W)
    ) u_step (
        .i_pos      (r_pos),
        .i_dir_up   (r_state == ST_WALK_UP),
        .i_size     (size),
        .i_pend     (r_pend),
        .i_rdata    (mem_rdata),
        .i_acc      (r_acc),
        .o_ctl      (step_ctl),
        .o_inc_cell (inc_cell),
        .o_acc_next (acc_next)
    );

    // write port: clearing pass or read-modify-write of a bumped cell
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr_addr;
        mem_wdata = inc_cell;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else if ((r_state == ST_WALK_UP) && r_pend) begin
            mem_we = 1'b1;
        end
    end

    fce_cell_ram #(
        .DEPTH (MAX_POSITIONS),
        .AW    (AW),
        .DW    (CELL_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    // prefix difference, clamped at zero; the count limit is applied in the finish state
    always_comb begin
        diff      = (r_sum_hi > r_acc) ? (r_sum_hi - r_acc) : '0;
        diff_wide = 48'(diff);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_pend       = 1'b0;
        n_valid      = 1'b0;
        n_pos        = r_pos;
        n_wr_addr    = rd_addr;
        n_acc        = r_acc;
        n_sum_hi     = r_sum_hi;
        n_lo_m1      = r_lo_m1;
        n_op         = r_op;
        n_status     = r_status;
        n_count_out  = r_count_out;
        n_status_out = r_status_out;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(MAX_POSITIONS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_op     = i_op;
                    n_status = chk_status;
                    n_lo_m1  = i_low_pos - POS_W'(1);
                    n_pos    = {1'b0, i_high_pos};
                    n_acc    = '0;
                    if (chk_status != STATUS_OK) begin
                        n_state = ST_FINISH;
                    end else if (i_op == OP_INC) begin
                        n_state = ST_WALK_UP;
                    end else begin
                        n_state = ST_WALK_HI;
                    end
                end
            end
            ST_WALK_UP: begin
                n_pend = step_ctl.pos_ok;
                n_pos  = step_ctl.next_pos;
                if (!step_ctl.pos_ok) begin
                    n_state = ST_FINISH;
                end
            end
            ST_WALK_HI: begin
                n_pend = step_ctl.pos_ok;
                n_pos  = step_ctl.next_pos;
                n_acc  = acc_next;
                if (!step_ctl.pos_ok) begin
                    n_sum_hi = acc_next;
                    n_acc    = '0;
                    n_pos    = {1'b0, r_lo_m1};
                    n_state  = ST_WALK_LO;
                end
            end
            ST_WALK_LO: begin
                n_pend = step_ctl.pos_ok;
                n_pos  = step_ctl.next_pos;
                n_acc  = acc_next;
                if (!step_ctl.pos_ok) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_valid      = 1'b1;
                n_status_out = r_status;
                n_count_out  = '0;
                if ((r_op == OP_COUNT) && (r_status == STATUS_OK)) begin
                    n_count_out = (diff_wide > COUNT_MAX) ? '1 : diff_wide[COUNT_W-1:0];
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_pend   <= 1'b0;
            r_valid  <= 1'b0;
            r_n_used <= N_USED_RST;
        end else begin
            r_clr   <= n_clr;
            r_pend  <= n_pend && walking;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_n_used <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_wr_addr    <= n_wr_addr;
        r_acc        <= n_acc;
        r_sum_hi     <= n_sum_hi;
        r_lo_m1      <= n_lo_m1;
        r_op         <= n_op;
        r_status     <= n_status;
        r_count_out  <= n_count_out;
        r_status_out <= n_status_out;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_range_count = r_count_out;
    assign o_status      = r_status_out;

endmodule

/* hdl/fce_cell_ram.sv */
// fce_cell_ram: tree cell storage, one write port and one registered read port
// depends on nothing but its parameters

module fce_cell_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/fce_step_unit.sv */
// fce_step_unit: shared lowbit step, saturating cell bump and accumulate
// depends on fce_pkg

module fce_step_unit
    import fce_pkg::*;
#(
    parameter int CELL_BITS = 16,
    parameter int ACC_W     = 20
) (
    input  logic [WALK_W-1:0]    i_pos,
    input  logic                 i_dir_up,
    input  logic [POS_W-1:0]     i_size,
    input  logic                 i_pend,
    input  logic [CELL_BITS-1:0] i_rdata,
    input  logic [ACC_W-1:0]     i_acc,
    output t_step_ctl            o_ctl,
    output logic [CELL_BITS-1:0] o_inc_cell,
    output logic [ACC_W-1:0]     o_acc_next
);

    logic [WALK_W-1:0] lowbit;
    logic              in_size;

    // lowbit chain step, up for increments and down for prefix sums
    always_comb begin
        lowbit         = i_pos & (~i_pos + WALK_W'(1));
        in_size        = i_pos <= {1'b0, i_size};
        o_ctl.next_pos = i_dir_up ? (i_pos + lowbit) : (i_pos - lowbit);
        o_ctl.pos_ok   = (i_pos != '0) && (!i_dir_up || in_size);
    end

    // saturating cell bump and prefix accumulate
    always_comb begin
        o_inc_cell = (i_rdata == '1) ? i_rdata : (i_rdata + CELL_BITS'(1));
        o_acc_next = i_pend ? (i_acc + ACC_W'(i_rdata)) : i_acc;
    end

endmodule

/* hdl/fce_checker.sv */
// fce_port_checker: port-level assertions on the fenwick count engine
// depends on fce_pkg; bound to fenwick_count_engine below

module fce_port_checker
    import fce_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic [COUNT_W-1:0] o_range_count,
    input logic [STAT_W-1:0]  o_status
);

    // an accepted word keeps the engine busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting a word");

    // the result strobe comes as the engine turns idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // one strobe per word, never two in a row
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // failed words report a zero count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STATUS_OK)) |-> (o_range_count == '0))
        else $error("nonzero count with error status");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == STATUS_OK) || (o_status == STATUS_RANGE) ||
                     (o_status == STATUS_ORDER)))
        else $error("undefined status code");

endmodule

bind fenwick_count_engine fce_port_checker u_fce_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_range_count (o_range_count),
    .o_status      (o_status)
);
